@@ sv/lrukv_pkg.sv @@
// Shared constants and types for the LRU key-value cache.
package lrukv_pkg;

  localparam int DEF_MAX_ENTRIES = 16;
  localparam int DATA_W          = 32;
  localparam int CAP_W           = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_DECIDE = 6'b000100,
    ST_VREAD  = 6'b001000,
    ST_PROMO  = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

endpackage

@@ sv/lrukv_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lrukv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

@@ sv/lru_key_value_cache_unit.sv @@
// Fully associative LRU key-value cache: top level with scan sequencer.
// One pass over the key/rank RAMs per lookup and per rank update. One transaction in flight:
// the next is accepted once the result is registered, which waits while an earlier result
// is still held.
// Reset (rst_n, synchronous): entries invalid, occupancy zero, capacity 16; RAMs not cleared.
module lru_key_value_cache_unit #(
  parameter int MAX_ENTRIES = lrukv_pkg::DEF_MAX_ENTRIES
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_operation,
  input  logic signed [lrukv_pkg::DATA_W-1:0]  in_key,
  input  logic signed [lrukv_pkg::DATA_W-1:0]  in_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_hit,
  output logic signed [lrukv_pkg::DATA_W-1:0] out_read_value,
  output logic                                 out_evicted,
  input  logic                                 cfg_wr_en,
  input  logic [lrukv_pkg::CAP_W-1:0]          cfg_wr_data
);
  import lrukv_pkg::*;

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int EW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ENTRIES - 1);

  state_t             state_r, state_nxt;
  logic               op_r, op_nxt;
  logic [DATA_W-1:0]  key_r, key_nxt;
  logic [DATA_W-1:0]  val_r, val_nxt;
  logic [CW-1:0]      rd_idx_r, rd_idx_nxt;
  logic               chk_vld_r, chk_vld_nxt;
  logic [IW-1:0]      chk_idx_r, chk_idx_nxt;
  logic               found_vld_r, found_vld_nxt;
  logic [IW-1:0]      found_idx_r, found_idx_nxt;
  logic [IW-1:0]      found_rank_r, found_rank_nxt;
  logic               vict_vld_r, vict_vld_nxt;
  logic [IW-1:0]      vict_idx_r, vict_idx_nxt;
  logic [IW-1:0]      vict_rank_r, vict_rank_nxt;
  logic               free_vld_r, free_vld_nxt;
  logic [IW-1:0]      free_idx_r, free_idx_nxt;
  logic [IW-1:0]      slot_r, slot_nxt;
  logic [IW-1:0]      limit_r, limit_nxt;
  logic               full_r, full_nxt;
  logic               hit_r, hit_nxt;
  logic               ev_r, ev_nxt;
  logic [DATA_W-1:0]  rdval_r, rdval_nxt;
  logic [MAX_ENTRIES-1:0] valid_r, valid_nxt;
  logic [CW-1:0]      occ_r, occ_nxt;
  logic [CAP_W-1:0]   cap_r, cap_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_hit_r, out_hit_nxt;
  logic [DATA_W-1:0]  out_rdval_r, out_rdval_nxt;
  logic               out_ev_r, out_ev_nxt;

  // RAM ports
  logic               key_we, val_we, rank_we;
  logic [IW-1:0]      key_waddr, val_waddr;
  logic [IW-1:0]      scan_addr;
  logic [DATA_W-1:0]  key_rd, val_rd;
  logic [IW-1:0]      rank_rd, rank_wdata;

  // Decision helpers
  logic [EW-1:0]      cap_ext, cap_eff;
  logic               at_cap, do_evict, slot_ok, use_victim, chk_valid, in_acc;

  assign scan_addr = rd_idx_r[IW-1:0];
  assign chk_valid = valid_r[chk_idx_r];
  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;

  assign cap_ext = EW'(cap_r);
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = EW'(1);
    end else if (cap_ext > EW'(MAX_ENTRIES)) begin
      cap_eff = EW'(MAX_ENTRIES);
    end else begin
      cap_eff = cap_ext;
    end
  end

  assign at_cap     = (EW'(occ_r) >= cap_eff);
  assign do_evict   = at_cap && vict_vld_r;
  assign use_victim = do_evict && (!free_vld_r || (vict_idx_r < free_idx_r));
  assign slot_ok    = do_evict || free_vld_r;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    rd_idx_nxt     = rd_idx_r;
    chk_vld_nxt    = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    found_vld_nxt  = found_vld_r;
    found_idx_nxt  = found_idx_r;
    found_rank_nxt = found_rank_r;
    vict_vld_nxt   = vict_vld_r;
    vict_idx_nxt   = vict_idx_r;
    vict_rank_nxt  = vict_rank_r;
    free_vld_nxt   = free_vld_r;
    free_idx_nxt   = free_idx_r;
    slot_nxt       = slot_r;
    limit_nxt      = limit_r;
    full_nxt       = full_r;
    hit_nxt        = hit_r;
    ev_nxt         = ev_r;
    rdval_nxt      = rdval_r;
    valid_nxt      = valid_r;
    occ_nxt        = occ_r;
    cap_nxt        = cfg_wr_en ? cfg_wr_data : cap_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_hit_nxt    = out_hit_r;
    out_rdval_nxt  = out_rdval_r;
    out_ev_nxt     = out_ev_r;
    key_we         = 1'b0;
    key_waddr      = slot_r;
    val_we         = 1'b0;
    val_waddr      = slot_r;
    rank_we        = 1'b0;
    rank_wdata     = rank_rd + IW'(1);

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt        = in_operation;
          key_nxt       = in_key;
          val_nxt       = in_value;
          rd_idx_nxt    = '0;
          found_vld_nxt = 1'b0;
          vict_vld_nxt  = 1'b0;
          free_vld_nxt  = 1'b0;
          hit_nxt       = 1'b0;
          ev_nxt        = 1'b0;
          rdval_nxt     = '0;
          state_nxt     = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // issue one read per cycle; data for chk_idx_r arrives in the following cycle
        if (rd_idx_r != CW'(MAX_ENTRIES)) begin
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = scan_addr;
          rd_idx_nxt  = rd_idx_r + CW'(1);
        end
        if (chk_vld_r) begin
          if (chk_valid && (key_rd == key_r) && !found_vld_r) begin
            found_vld_nxt  = 1'b1;
            found_idx_nxt  = chk_idx_r;
            found_rank_nxt = rank_rd;
          end
          if (chk_valid && (!vict_vld_r || (rank_rd > vict_rank_r))) begin
            vict_vld_nxt  = 1'b1;
            vict_idx_nxt  = chk_idx_r;
            vict_rank_nxt = rank_rd;
          end
          if (!chk_valid && !free_vld_r) begin
            free_vld_nxt = 1'b1;
            free_idx_nxt = chk_idx_r;
          end
          if (chk_idx_r == LAST_IDX) begin
            state_nxt = ST_DECIDE;
          end
        end
      end

      ST_DECIDE: begin
        rd_idx_nxt = '0;
        if (found_vld_r) begin
          hit_nxt   = 1'b1;
          slot_nxt  = found_idx_r;
          limit_nxt = found_rank_r;
          full_nxt  = 1'b0;
          if (op_r == OP_PUT) begin
            val_we    = 1'b1;
            val_waddr = found_idx_r;
            state_nxt = ST_PROMO;
          end else begin
            state_nxt = ST_VREAD;
          end
        end else if (op_r == OP_PUT) begin
          if (do_evict) begin
            valid_nxt[vict_idx_r] = 1'b0;
            ev_nxt                = 1'b1;
          end
          if (slot_ok) begin
            slot_nxt  = use_victim ? vict_idx_r : free_idx_r;
            key_we    = 1'b1;
            key_waddr = use_victim ? vict_idx_r : free_idx_r;
            val_we    = 1'b1;
            val_waddr = use_victim ? vict_idx_r : free_idx_r;
            valid_nxt[use_victim ? vict_idx_r : free_idx_r] = 1'b1;
            full_nxt  = 1'b1;
            // evict and insert together leave occupancy unchanged
            occ_nxt   = do_evict ? occ_r : occ_r + CW'(1);
            state_nxt = ST_PROMO;
          end else begin
            occ_nxt   = do_evict ? occ_r - CW'(1) : occ_r;
            state_nxt = ST_DONE;
          end
        end else begin
          state_nxt = ST_DONE;
        end
      end

      ST_VREAD: begin
        rdval_nxt = val_rd;
        state_nxt = ST_PROMO;
      end

      ST_PROMO: begin
        if (rd_idx_r != CW'(MAX_ENTRIES)) begin
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = scan_addr;
          rd_idx_nxt  = rd_idx_r + CW'(1);
        end
        if (chk_vld_r) begin
          if (chk_idx_r == slot_r) begin
            rank_we    = 1'b1;
            rank_wdata = '0;
          end else if (chk_valid && (full_r || (rank_rd < limit_r))) begin
            rank_we = 1'b1;
          end
          if (chk_idx_r == LAST_IDX) begin
            state_nxt = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = hit_r;
          out_rdval_nxt = rdval_r;
          out_ev_nxt    = ev_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      chk_vld_r   <= 1'b0;
      valid_r     <= '0;
      occ_r       <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chk_vld_r   <= chk_vld_nxt;
      valid_r     <= valid_nxt;
      occ_r       <= occ_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    rd_idx_r     <= rd_idx_nxt;
    chk_idx_r    <= chk_idx_nxt;
    found_vld_r  <= found_vld_nxt;
    found_idx_r  <= found_idx_nxt;
    found_rank_r <= found_rank_nxt;
    vict_vld_r   <= vict_vld_nxt;
    vict_idx_r   <= vict_idx_nxt;
    vict_rank_r  <= vict_rank_nxt;
    free_vld_r   <= free_vld_nxt;
    free_idx_r   <= free_idx_nxt;
    slot_r       <= slot_nxt;
    limit_r      <= limit_nxt;
    full_r       <= full_nxt;
    hit_r        <= hit_nxt;
    ev_r         <= ev_nxt;
    rdval_r      <= rdval_nxt;
    out_hit_r    <= out_hit_nxt;
    out_rdval_r  <= out_rdval_nxt;
    out_ev_r     <= out_ev_nxt;
  end

  lrukv_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_r),
    .raddr (scan_addr),
    .rdata (key_rd)
  );

  lrukv_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ENTRIES)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_r),
    .raddr (found_idx_r),
    .rdata (val_rd)
  );

  lrukv_ram #(.WIDTH(IW), .DEPTH(MAX_ENTRIES)) u_rank_ram (
    .clk   (clk),
    .we    (rank_we),
    .waddr (chk_idx_r),
    .wdata (rank_wdata),
    .raddr (scan_addr),
    .rdata (rank_rd)
  );

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_rdval_r;
  assign out_evicted    = out_ev_r;

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// Testbench for the LRU key-value cache: directed and random get/put traffic checked by a predictor.
module tb;
  import lrukv_pkg::*;

  localparam int MAX_SLOTS    = DEF_MAX_ENTRIES;
  localparam int DRAIN_CYCLES = 2 * MAX_SLOTS + 13;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
    logic        evicted;
  } lookup_result_t;

  logic                     clk;
  logic                     rst_n        = 1'b0;
  logic                     in_valid     = 1'b0;
  logic                     in_ready;
  logic                     in_operation = OP_GET;
  logic signed [DATA_W-1:0] in_key       = '0;
  logic signed [DATA_W-1:0] in_value     = '0;
  logic                     out_valid;
  logic                     out_ready    = 1'b0;
  logic                     out_hit;
  logic signed [DATA_W-1:0] out_read_value;
  logic                     out_evicted;
  logic                     cfg_wr_en    = 1'b0;
  logic [CAP_W-1:0]         cfg_wr_data  = '0;

  // predictor state
  logic [31:0]      slot_key [MAX_SLOTS];
  logic [31:0]      slot_val [MAX_SLOTS];
  logic             slot_live [MAX_SLOTS];
  int               slot_rank [MAX_SLOTS];
  int               live_count;
  logic [CAP_W-1:0] cap_setting;

  lookup_result_t pending_results [$];
  int             err_count = 0;
  int             send_gap_pct = 22;
  int             stall_pct = 78;

  lru_key_value_cache_unit #(.MAX_ENTRIES(MAX_SLOTS)) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .out_evicted    (out_evicted),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    err_count++;
  endtask

  // Age every live entry newer than limit by one, then make slot s the newest.
  function automatic void bump_ranks(input int s, input int limit);
    for (int i = 0; i < MAX_SLOTS; i++)
      if (slot_live[i] && i != s && slot_rank[i] < limit) slot_rank[i]++;
    slot_rank[s] = 0;
  endfunction

  function automatic void cache_predict(input logic op, input logic [31:0] k,
                                        input logic [31:0] v);
    lookup_result_t r;
    int found;
    int victim;
    int best;
    int slot;
    int eff_cap;
    r.hit        = 1'b0;
    r.read_value = '0;
    r.evicted    = 1'b0;
    found        = -1;
    for (int i = 0; i < MAX_SLOTS; i++)
      if (found < 0 && slot_live[i] && slot_key[i] == k) found = i;
    if (found >= 0) begin
      r.hit = 1'b1;
      if (op == OP_GET) r.read_value = slot_val[found];
      else slot_val[found] = v;
      bump_ranks(found, slot_rank[found]);
    end else if (op == OP_PUT) begin
      eff_cap = int'(cap_setting);
      if (eff_cap < 1) eff_cap = 1;
      if (eff_cap > MAX_SLOTS) eff_cap = MAX_SLOTS;
      if (live_count >= eff_cap) begin
        victim = -1;
        best   = 0;
        for (int i = 0; i < MAX_SLOTS; i++) begin
          if (slot_live[i] && (victim < 0 || slot_rank[i] > best)) begin
            victim = i;
            best   = slot_rank[i];
          end
        end
        if (victim >= 0) begin
          slot_live[victim] = 1'b0;
          live_count--;
          r.evicted = 1'b1;
        end
      end
      slot = -1;
      for (int i = 0; i < MAX_SLOTS; i++)
        if (slot < 0 && !slot_live[i]) slot = i;
      if (slot >= 0) begin
        slot_key[slot]  = k;
        slot_val[slot]  = v;
        slot_live[slot] = 1'b1;
        bump_ranks(slot, MAX_SLOTS);
        live_count++;
      end
    end
    pending_results.push_back(r);
  endfunction

  // Random backpressure on the result side.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    lookup_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transaction with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (out_hit !== want.hit)
          report_mismatch($sformatf("hit expected %0b got %0b", want.hit, out_hit));
        if (out_read_value !== want.read_value)
          report_mismatch($sformatf("read_value expected %h got %h",
                                    want.read_value, out_read_value));
        if (out_evicted !== want.evicted)
          report_mismatch($sformatf("evicted expected %0b got %0b",
                                    want.evicted, out_evicted));
      end
    end
  end

  // Returns just after the posedge at which the transaction was accepted.
  task automatic send_req(input logic op, input logic [31:0] k, input logic [31:0] v);
    @(negedge clk);
    if ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < send_gap_pct);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_key       <= k;
    in_value     <= v;
    do @(posedge clk); while (!in_ready);
    cache_predict(op, k, v);
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    wait_quiet();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    cap_setting = cap;
  endtask

  task automatic test_basic_ops();
    send_req(OP_GET, 32'h8000_0000, 32'h1234_5678);
    send_req(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_req(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_req(OP_PUT, 32'h0000_0000, 32'h0000_0000);
    send_req(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    send_req(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    // overwrite a present key, then read it back
    send_req(OP_PUT, 32'h0000_0000, 32'h5A5A_A5A5);
    send_req(OP_GET, 32'h0000_0000, 32'h0000_0000);
    send_req(OP_GET, 32'h0000_3039, 32'h0000_0000);
  endtask

  task automatic test_small_capacity();
    // zero acts as one: each new key evicts the least recently used entry
    set_capacity(5'd0);
    send_req(OP_PUT, 32'h0000_00A1, 32'h1111_1111);
    send_req(OP_PUT, 32'h0000_00B2, 32'h2222_2222);
    send_req(OP_GET, 32'h0000_00A1, 32'h0);
    send_req(OP_GET, 32'h0000_00B2, 32'h0);
    set_capacity(5'd2);
    send_req(OP_PUT, 32'h0000_00C3, 32'h3333_3333);
    send_req(OP_GET, 32'h0000_00B2, 32'h0);
    send_req(OP_PUT, 32'h0000_00D4, 32'h4444_4444);
    send_req(OP_GET, 32'h0000_00C3, 32'h0);
  endtask

  task automatic run_random_phase(input int n_items, input logic [CAP_W-1:0] cap);
    logic [31:0] pool [32];
    int          pool_size;
    int          eff_cap;
    logic [31:0] k;
    logic        op;
    set_capacity(cap);
    eff_cap = int'(cap);
    if (eff_cap < 1) eff_cap = 1;
    if (eff_cap > MAX_SLOTS) eff_cap = MAX_SLOTS;
    // keep the key pool a little larger than the capacity so hits and evictions mix
    pool_size = eff_cap + int'($urandom_range(1, 6));
    for (int i = 0; i < pool_size; i++) pool[i] = $urandom();
    for (int n = 0; n < n_items; n++) begin
      op = $urandom_range(0, 1) ? OP_PUT : OP_GET;
      if ($urandom_range(0, 9) == 0) k = $urandom();
      else k = pool[$urandom_range(0, pool_size - 1)];
      send_req(op, k, $urandom());
    end
  endtask

  task automatic test_random_traffic();
    logic [CAP_W-1:0] caps [9];
    caps = '{5'd31, 5'd3, 5'd0, 5'd16, 5'd1, 5'd8, 5'd17, 5'd2, 5'd12};
    for (int p = 0; p < 9; p++) begin
      if (p < 3) begin
        send_gap_pct = 22;
        stall_pct    = 78;
      end else if (p < 6) begin
        send_gap_pct = 78;
        stall_pct    = 22;
      end else begin
        send_gap_pct = 0;
        stall_pct    = 0;
      end
      run_random_phase(100, caps[p]);
    end
  endtask

  initial begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      slot_key[i]  = '0;
      slot_val[i]  = '0;
      slot_live[i] = 1'b0;
      slot_rank[i] = 0;
    end
    live_count  = 0;
    cap_setting = CAP_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_basic_ops();
    test_small_capacity();
    test_random_traffic();
    wait_quiet();
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
